/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the core.
// No dependencies; taken in by `include where a module asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lrsc_pkg.sv */
// Package for the low-rank Schur complement block: codes, command struct,
// fixed-point helpers. No dependencies.
package lrsc_pkg;

   localparam int N_MAX_DEF = 32;
   localparam int R_MAX_DEF = 64;
   localparam int M_MAX_DEF = 8;

   // action codes
   localparam logic [2:0] ACT_LOAD_W     = 3'd0;
   localparam logic [2:0] ACT_LOAD_V     = 3'd1;
   localparam logic [2:0] ACT_LOAD_ALPHA = 3'd2;
   localparam logic [2:0] ACT_LOAD_BND   = 3'd3;
   localparam logic [2:0] ACT_START      = 3'd4;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'b1;

   localparam logic signed [63:0] Q32_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q32_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [47:0] Q16_HI  = 48'sh0000_7FFF_FFFF;
   localparam logic signed [47:0] Q16_LO  = 48'shFFFF_8000_0000;

   typedef enum logic [1:0] {
      MUL_WV    = 2'd0,
      MUL_VWV   = 2'd1,
      MUL_ALPHA = 2'd2,
      MUL_TD    = 2'd3
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        mul_en;
      logic        acc_en;
      logic        acc_first;
      logic        vw_we;
      logic        d_en;
      logic        ak_en;
      logic        t_en;
      logic        sum_clr;
      logic        sum_en;
      logic        m_we;
      logic        out_ld;
      logic        out_last;
      logic [2:0]  out_row;
      logic [2:0]  out_col;
   } dp_cmd_type;

   function automatic int addr_w(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? Q32_MIN : Q32_MAX;
      end
      return s;
   endfunction

   // Q32.32 -> Q16.16, round half up, saturate
   function automatic logic signed [31:0] round_sat(input logic signed [63:0] x);
      logic signed [63:0] y;
      logic signed [47:0] q;
      y = sat_add64(x, 64'sd32768);
      q = y[63:16];
      if (q > Q16_HI) begin
         q = Q16_HI;
      end else if (q < Q16_LO) begin
         q = Q16_LO;
      end
      return q[31:0];
   endfunction

endpackage

/* rtl/core/lrsc_dp.sv */
// Datapath: stores for W, V, vW, alpha, boundaries and M, the shared
// multiplier, accumulators and result register. Depends on lrsc_pkg.
module lrsc_dp import lrsc_pkg::*; #(
   parameter int N_MAX = N_MAX_DEF,
   parameter int R_MAX = R_MAX_DEF,
   parameter int M_MAX = M_MAX_DEF,
   localparam int W_AW = addr_w(N_MAX * N_MAX),
   localparam int V_AW = addr_w(N_MAX * R_MAX),
   localparam int A_AW = addr_w(R_MAX),
   localparam int B_AW = addr_w(M_MAX + 1),
   localparam int M_AW = addr_w(M_MAX * M_MAX)
) (
   input  logic               clock,
   input  logic               load_en,
   input  logic [2:0]         req_action,
   input  logic [4:0]         req_row_index,
   input  logic [5:0]         req_col_index,
   input  logic signed [31:0] req_value,
   input  logic [3:0]         req_block_index,
   input  logic [6:0]         req_block_boundary,
   input  dp_cmd_type         cmd,
   input  logic [W_AW-1:0]    w_raddr,
   input  logic [V_AW-1:0]    v_raddr,
   input  logic [V_AW-1:0]    vw_raddr,
   input  logic [V_AW-1:0]    vw_waddr,
   input  logic [A_AW-1:0]    alpha_raddr,
   input  logic [B_AW-1:0]    bnd_raddr,
   input  logic [M_AW-1:0]    m_addr,
   output logic [6:0]         bnd_rdata,
   output logic [2:0]         rsp_out_row,
   output logic [2:0]         rsp_out_col,
   output logic signed [63:0] rsp_out_value,
   output logic               rsp_last
);

   logic signed [31:0] w_mem     [N_MAX*N_MAX];
   logic signed [31:0] v_mem     [N_MAX*R_MAX];
   logic signed [31:0] vw_mem    [N_MAX*R_MAX];
   logic signed [31:0] alpha_mem [R_MAX];
   logic [6:0]         bnd_mem   [M_MAX+1];
   logic signed [63:0] m_mem     [M_MAX*M_MAX];

   logic signed [31:0] w_rdata_ff, v_rdata_ff, vw_rdata_ff, alpha_rdata_ff;
   logic [6:0]         bnd_rdata_ff;
   logic signed [63:0] m_rdata_ff;

   logic signed [63:0] prod_ff, acc_ff, sum_ff;
   logic signed [31:0] d_ff, ak_ff, t_ff;
   logic [2:0]         row_ff, col_ff;
   logic signed [63:0] value_ff;
   logic               last_ff;

   logic               w_we, v_we, alpha_we, bnd_we;
   logic [W_AW-1:0]    w_waddr;
   logic [V_AW-1:0]    v_waddr;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic signed [63:0] acc_in;

   // load decode
   assign w_we     = load_en && req_action == ACT_LOAD_W &&
                     req_row_index < N_MAX && req_col_index < N_MAX;
   assign v_we     = load_en && req_action == ACT_LOAD_V &&
                     req_row_index < N_MAX && req_col_index < R_MAX;
   assign alpha_we = load_en && req_action == ACT_LOAD_ALPHA && req_col_index < R_MAX;
   assign bnd_we   = load_en && req_action == ACT_LOAD_BND && req_block_index <= M_MAX;
   assign w_waddr  = W_AW'(req_row_index * N_MAX + req_col_index);
   assign v_waddr  = V_AW'(req_col_index * N_MAX + req_row_index);

   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[w_waddr] <= req_value;
      end
      w_rdata_ff <= w_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         v_mem[v_waddr] <= req_value;
      end
      v_rdata_ff <= v_mem[v_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.vw_we) begin
         vw_mem[vw_waddr] <= round_sat(acc_ff);
      end
      vw_rdata_ff <= vw_mem[vw_raddr];
   end

   always_ff @(posedge clock) begin
      if (alpha_we) begin
         alpha_mem[A_AW'(req_col_index)] <= req_value;
      end
      alpha_rdata_ff <= alpha_mem[alpha_raddr];
   end

   always_ff @(posedge clock) begin
      if (bnd_we) begin
         bnd_mem[B_AW'(req_block_index)] <= req_block_boundary;
      end
      bnd_rdata_ff <= bnd_mem[bnd_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.m_we) begin
         m_mem[m_addr] <= sum_ff;
      end
      m_rdata_ff <= m_mem[m_addr];
   end

   // shared multiplier operands
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_WV: begin
            mul_a = w_rdata_ff;
            mul_b = v_rdata_ff;
         end
         MUL_VWV: begin
            mul_a = vw_rdata_ff;
            mul_b = v_rdata_ff;
         end
         MUL_ALPHA: begin
            mul_a = ak_ff;
            mul_b = alpha_rdata_ff;
         end
         MUL_TD: begin
            mul_a = t_ff;
            mul_b = d_ff;
         end
         default: begin
            mul_a = t_ff;
            mul_b = d_ff;
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign acc_in = cmd.acc_first ? prod_ff : sat_add64(acc_ff, prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.d_en) begin
         d_ff <= round_sat(acc_ff);
      end
      if (cmd.ak_en) begin
         ak_ff <= alpha_rdata_ff;
      end
      if (cmd.t_en) begin
         t_ff <= round_sat(prod_ff);
      end
      if (cmd.sum_clr) begin
         sum_ff <= '0;
      end else if (cmd.sum_en) begin
         sum_ff <= sat_add64(sum_ff, prod_ff);
      end
      if (cmd.out_ld) begin
         row_ff   <= cmd.out_row;
         col_ff   <= cmd.out_col;
         value_ff <= m_rdata_ff;
         last_ff  <= cmd.out_last;
      end
   end

   assign bnd_rdata     = bnd_rdata_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_value = value_ff;
   assign rsp_last      = last_ff;

endmodule

/* rtl/core/lrsc_ctrl.sv */
// Controller: configuration registers, loop counters and the sequencing
// state machine that drives the datapath. Depends on lrsc_pkg, assert_macros.
`include "assert_macros.svh"

module lrsc_ctrl import lrsc_pkg::*; #(
   parameter int N_MAX = N_MAX_DEF,
   parameter int R_MAX = R_MAX_DEF,
   parameter int M_MAX = M_MAX_DEF,
   localparam int W_AW = addr_w(N_MAX * N_MAX),
   localparam int V_AW = addr_w(N_MAX * R_MAX),
   localparam int A_AW = addr_w(R_MAX),
   localparam int B_AW = addr_w(M_MAX + 1),
   localparam int M_AW = addr_w(M_MAX * M_MAX)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [2:0]            req_action,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [6:0]            bnd_rdata,
   output dp_cmd_type            cmd,
   output logic [W_AW-1:0]       w_raddr,
   output logic [V_AW-1:0]       v_raddr,
   output logic [V_AW-1:0]       vw_raddr,
   output logic [V_AW-1:0]       vw_waddr,
   output logic [A_AW-1:0]       alpha_raddr,
   output logic [B_AW-1:0]       bnd_raddr,
   output logic [M_AW-1:0]       m_addr
);

   localparam int NC_W = $clog2(N_MAX + 1);
   localparam int RC_W = $clog2(R_MAX + 1);
   localparam int MC_W = $clog2(M_MAX + 1);

   typedef enum logic [23:0] {
      ST_IDLE     = 24'h000001,
      ST_VW_RD    = 24'h000002,
      ST_VW_MUL   = 24'h000004,
      ST_VW_ACC   = 24'h000008,
      ST_VW_WR    = 24'h000010,
      ST_BND_RD   = 24'h000020,
      ST_BND_LAT  = 24'h000040,
      ST_PAIR     = 24'h000080,
      ST_DOT_RD   = 24'h000100,
      ST_DOT_MUL  = 24'h000200,
      ST_DOT_ACC  = 24'h000400,
      ST_D_RS     = 24'h000800,
      ST_AK_LAT   = 24'h001000,
      ST_AL_MUL   = 24'h002000,
      ST_T1       = 24'h004000,
      ST_T2_MUL   = 24'h008000,
      ST_T2       = 24'h010000,
      ST_TERM_MUL = 24'h020000,
      ST_TERM_ACC = 24'h040000,
      ST_M_WR1    = 24'h080000,
      ST_M_WR2    = 24'h100000,
      ST_OUT_RD   = 24'h200000,
      ST_OUT_LD   = 24'h400000,
      ST_OUT_WAIT = 24'h800000
   } state_type;

   state_type       state_ff, state_in;
   logic [5:0]      size_ff, size_in;
   logic [3:0]      blocks_ff, blocks_in;
   logic [NC_W-1:0] r_ff, r_in, c_ff, c_in;
   logic [RC_W-1:0] k_ff, k_in, l_ff, l_in;
   logic [RC_W-1:0] k0_ff, k0_in, k1_ff, k1_in, l0_ff, l0_in, l1_ff, l1_in;
   logic [MC_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [1:0]      bsel_ff, bsel_in;
   logic            valid_ff, valid_in;

   logic [NC_W-1:0] n_w, n_last;
   logic [MC_W-1:0] m_w, m_last;
   logic [RC_W-1:0] bnd_clamp;
   logic            r_last, c_last, last_w;
   logic [MC_W-1:0] bnd_idx;

   // effective sizes, clamped to the supported range
   always_comb begin
      if (size_ff == '0) begin
         n_w = NC_W'(1);
      end else if (size_ff > N_MAX) begin
         n_w = NC_W'(N_MAX);
      end else begin
         n_w = NC_W'(size_ff);
      end
      if (blocks_ff == '0) begin
         m_w = MC_W'(1);
      end else if (blocks_ff > M_MAX) begin
         m_w = MC_W'(M_MAX);
      end else begin
         m_w = MC_W'(blocks_ff);
      end
   end

   assign n_last    = n_w - NC_W'(1);
   assign m_last    = m_w - MC_W'(1);
   assign r_last    = (r_ff == n_last);
   assign c_last    = (c_ff == n_last);
   assign last_w    = (i_ff == m_last) && (j_ff == m_last);
   assign bnd_clamp = (bnd_rdata > R_MAX) ? RC_W'(R_MAX) : RC_W'(bnd_rdata);

   always_comb begin
      unique case (bsel_ff)
         2'd0:    bnd_idx = i_ff;
         2'd1:    bnd_idx = i_ff + MC_W'(1);
         2'd2:    bnd_idx = j_ff;
         2'd3:    bnd_idx = j_ff + MC_W'(1);
         default: bnd_idx = i_ff;
      endcase
   end

   // memory addresses
   assign w_raddr     = W_AW'(r_ff * N_MAX + c_ff);
   assign v_raddr     = (state_ff == ST_VW_RD) ? V_AW'(k_ff * N_MAX + r_ff)
                                               : V_AW'(l_ff * N_MAX + r_ff);
   assign vw_raddr    = V_AW'(k_ff * N_MAX + r_ff);
   assign vw_waddr    = V_AW'(k_ff * N_MAX + c_ff);
   assign alpha_raddr = (state_ff == ST_AK_LAT) ? A_AW'(l_ff) : A_AW'(k_ff);
   assign bnd_raddr   = B_AW'(bnd_idx);
   assign m_addr      = (state_ff == ST_M_WR2) ? M_AW'(j_ff * M_MAX + i_ff)
                                               : M_AW'(i_ff * M_MAX + j_ff);

   always_comb begin
      state_in  = state_ff;
      size_in   = size_ff;
      blocks_in = blocks_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      l_in      = l_ff;
      k0_in     = k0_ff;
      k1_in     = k1_ff;
      l0_in     = l0_ff;
      l1_in     = l1_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      bsel_in   = bsel_ff;
      valid_in  = valid_ff;

      cmd          = '0;
      cmd.mul_sel  = MUL_WV;
      cmd.out_row  = 3'(i_ff);
      cmd.out_col  = 3'(j_ff);
      cmd.out_last = last_w;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_IN_USE: size_in   = csr_wdata[5:0];
            CSR_BLOCK_COUNT: blocks_in = csr_wdata[3:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_action == ACT_START) begin
               k_in     = '0;
               c_in     = '0;
               r_in     = '0;
               state_in = ST_VW_RD;
            end
         end
         ST_VW_RD: state_in = ST_VW_MUL;
         ST_VW_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_WV;
            state_in    = ST_VW_ACC;
         end
         ST_VW_ACC: begin
            cmd.acc_en    = 1'b1;
            cmd.acc_first = (r_ff == '0);
            if (r_last) begin
               state_in = ST_VW_WR;
            end else begin
               r_in     = r_ff + NC_W'(1);
               state_in = ST_VW_RD;
            end
         end
         ST_VW_WR: begin
            cmd.vw_we = 1'b1;
            r_in      = '0;
            state_in  = ST_VW_RD;
            if (c_last) begin
               c_in = '0;
               if (k_ff == RC_W'(R_MAX - 1)) begin
                  i_in     = '0;
                  j_in     = '0;
                  bsel_in  = '0;
                  state_in = ST_BND_RD;
               end else begin
                  k_in = k_ff + RC_W'(1);
               end
            end else begin
               c_in = c_ff + NC_W'(1);
            end
         end
         ST_BND_RD: state_in = ST_BND_LAT;
         ST_BND_LAT: begin
            unique case (bsel_ff)
               2'd0:    k0_in = bnd_clamp;
               2'd1:    k1_in = bnd_clamp;
               2'd2:    l0_in = bnd_clamp;
               2'd3:    l1_in = bnd_clamp;
               default: k0_in = bnd_clamp;
            endcase
            if (bsel_ff == 2'd3) begin
               state_in = ST_PAIR;
            end else begin
               bsel_in  = bsel_ff + 2'd1;
               state_in = ST_BND_RD;
            end
         end
         ST_PAIR: begin
            cmd.sum_clr = 1'b1;
            k_in        = k0_ff;
            l_in        = l0_ff;
            r_in        = '0;
            // empty or reversed block on either side adds nothing
            if (k0_ff >= k1_ff || l0_ff >= l1_ff) begin
               state_in = ST_M_WR1;
            end else begin
               state_in = ST_DOT_RD;
            end
         end
         ST_DOT_RD: state_in = ST_DOT_MUL;
         ST_DOT_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_VWV;
            state_in    = ST_DOT_ACC;
         end
         ST_DOT_ACC: begin
            cmd.acc_en    = 1'b1;
            cmd.acc_first = (r_ff == '0);
            if (r_last) begin
               state_in = ST_D_RS;
            end else begin
               r_in     = r_ff + NC_W'(1);
               state_in = ST_DOT_RD;
            end
         end
         ST_D_RS: begin
            cmd.d_en = 1'b1;
            state_in = ST_AK_LAT;
         end
         ST_AK_LAT: begin
            cmd.ak_en = 1'b1;
            state_in  = ST_AL_MUL;
         end
         ST_AL_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ALPHA;
            state_in    = ST_T1;
         end
         ST_T1: begin
            cmd.t_en = 1'b1;
            state_in = ST_T2_MUL;
         end
         ST_T2_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_TD;
            state_in    = ST_T2;
         end
         ST_T2: begin
            cmd.t_en = 1'b1;
            state_in = ST_TERM_MUL;
         end
         ST_TERM_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_TD;
            state_in    = ST_TERM_ACC;
         end
         ST_TERM_ACC: begin
            cmd.sum_en = 1'b1;
            r_in       = '0;
            state_in   = ST_DOT_RD;
            if (l_ff == l1_ff - RC_W'(1)) begin
               l_in = l0_ff;
               if (k_ff == k1_ff - RC_W'(1)) begin
                  state_in = ST_M_WR1;
               end else begin
                  k_in = k_ff + RC_W'(1);
               end
            end else begin
               l_in = l_ff + RC_W'(1);
            end
         end
         ST_M_WR1: begin
            cmd.m_we = 1'b1;
            state_in = ST_M_WR2;
         end
         ST_M_WR2: begin
            cmd.m_we = 1'b1;
            bsel_in  = '0;
            state_in = ST_BND_RD;
            if (j_ff == m_last) begin
               if (i_ff == m_last) begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  i_in = i_ff + MC_W'(1);
                  j_in = i_ff + MC_W'(1);
               end
            end else begin
               j_in = j_ff + MC_W'(1);
            end
         end
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: begin
            cmd.out_ld = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               if (last_w) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_OUT_RD;
                  if (j_ff == m_last) begin
                     j_in = '0;
                     i_in = i_ff + MC_W'(1);
                  end else begin
                     j_in = j_ff + MC_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         size_ff   <= 6'd1;
         blocks_ff <= 4'd1;
         r_ff      <= '0;
         c_ff      <= '0;
         k_ff      <= '0;
         l_ff      <= '0;
         k0_ff     <= '0;
         k1_ff     <= '0;
         l0_ff     <= '0;
         l1_ff     <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         bsel_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         size_ff   <= size_in;
         blocks_ff <= blocks_in;
         r_ff      <= r_in;
         c_ff      <= c_in;
         k_ff      <= k_in;
         l_ff      <= l_in;
         k0_ff     <= k0_in;
         k1_ff     <= k1_in;
         l0_ff     <= l0_in;
         l1_ff     <= l1_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         bsel_ff   <= bsel_in;
         valid_ff  <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   `ASSERT_NEXT(a_start_busy, clock, reset, req_valid && !req_stall && req_action == ACT_START, state_ff == ST_VW_RD, "start transfer did not launch compute")
   `ASSERT_IMPLIES(a_valid_state, clock, reset, valid_ff, state_ff == ST_OUT_WAIT, "result valid outside output wait")
   `ASSERT_NEXT(a_last_idle, clock, reset, valid_ff && !rsp_stall && last_w, state_ff == ST_IDLE, "last transfer did not return to idle")
   `ASSERT_IMPLIES(a_dot_range, clock, reset, state_ff == ST_DOT_RD, (k_ff < k1_ff) && (l_ff < l1_ff), "vector index outside its block")

endmodule

/* rtl/core/low_rank_schur_complement.sv */
// Low-rank Schur complement engine. Load transfers (W, V, alpha, block
// boundaries) write straight into on-chip stores. A start transfer
// computes vW = W^T*V for all R_MAX vectors, then every block pair (i <= j)
// of M, then streams the m*m entries row-major with rsp_last on the final
// one; req_stall stays high from start until the last result transfer. All
// work runs through one 32x32 multiplier with registered memory reads. Each
// block pair fetches its boundaries, accumulates one term per (k,l) pair
// and then stores M(i,j) and M(j,i); each output entry is held while
// rsp_stall is high. Inputs are Q16.16; intermediate vW, dot products and
// weights are rounded half up and saturated to Q16.16; M accumulates
// saturating in Q32.32. Configuration (size_in_use, block_count) must be
// written only while idle; the block itself does not enforce this. Reads of
// never loaded entries return arbitrary data. Depends on lrsc_pkg,
// lrsc_ctrl, lrsc_dp.
module low_rank_schur_complement import lrsc_pkg::*; #(
   parameter int N_MAX = N_MAX_DEF,
   parameter int R_MAX = R_MAX_DEF,
   parameter int M_MAX = M_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_action,
   input  logic [4:0]            req_row_index,
   input  logic [5:0]            req_col_index,
   input  logic signed [31:0]    req_value,
   input  logic [3:0]            req_block_index,
   input  logic [6:0]            req_block_boundary,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_out_row,
   output logic [2:0]            rsp_out_col,
   output logic signed [63:0]    rsp_out_value,
   output logic                  rsp_last,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int W_AW = addr_w(N_MAX * N_MAX);
   localparam int V_AW = addr_w(N_MAX * R_MAX);
   localparam int A_AW = addr_w(R_MAX);
   localparam int B_AW = addr_w(M_MAX + 1);
   localparam int M_AW = addr_w(M_MAX * M_MAX);

   dp_cmd_type      cmd;
   logic [W_AW-1:0] w_raddr;
   logic [V_AW-1:0] v_raddr, vw_raddr, vw_waddr;
   logic [A_AW-1:0] alpha_raddr;
   logic [B_AW-1:0] bnd_raddr;
   logic [M_AW-1:0] m_addr;
   logic [6:0]      bnd_rdata;
   logic            load_en;

   // loads land only while idle, when stall is low
   assign load_en = req_valid && !req_stall;

   lrsc_ctrl #(
      .N_MAX(N_MAX),
      .R_MAX(R_MAX),
      .M_MAX(M_MAX)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_action  (req_action),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .bnd_rdata   (bnd_rdata),
      .cmd         (cmd),
      .w_raddr     (w_raddr),
      .v_raddr     (v_raddr),
      .vw_raddr    (vw_raddr),
      .vw_waddr    (vw_waddr),
      .alpha_raddr (alpha_raddr),
      .bnd_raddr   (bnd_raddr),
      .m_addr      (m_addr)
   );

   lrsc_dp #(
      .N_MAX(N_MAX),
      .R_MAX(R_MAX),
      .M_MAX(M_MAX)
   ) u_dp (
      .clock              (clock),
      .load_en            (load_en),
      .req_action         (req_action),
      .req_row_index      (req_row_index),
      .req_col_index      (req_col_index),
      .req_value          (req_value),
      .req_block_index    (req_block_index),
      .req_block_boundary (req_block_boundary),
      .cmd                (cmd),
      .w_raddr            (w_raddr),
      .v_raddr            (v_raddr),
      .vw_raddr           (vw_raddr),
      .vw_waddr           (vw_waddr),
      .alpha_raddr        (alpha_raddr),
      .bnd_raddr          (bnd_raddr),
      .m_addr             (m_addr),
      .bnd_rdata          (bnd_rdata),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_out_value      (rsp_out_value),
      .rsp_last           (rsp_last)
   );

endmodule
